FILE: sv/rlwq_pkg.sv
package rlwq_pkg;

  localparam int THREAD_BITS = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_BITS   = 16;

  localparam int QPTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUSED_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [NEST_BITS-1:0]  NEST_MAX   = {NEST_BITS{1'b1}};
  localparam logic [NEST_BITS-1:0]  NEST_ONE   = NEST_BITS'(1);
  localparam logic [QPTR_BITS-1:0]  QPTR_LAST  = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QUSED_BITS-1:0] QUSED_FULL = QUSED_BITS'(QUEUE_DEPTH);

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NOT_HOLDER = 2'd1,
    ERR_QUEUE_FULL = 2'd2,
    ERR_NEST_SAT   = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

FILE: sv/rlwq_in_if.sv
interface rlwq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [rlwq_pkg::THREAD_BITS-1:0] thread;

  modport source (output valid, output command, output thread, input ready);
  modport sink   (input valid, input command, input thread, output ready);
endinterface

FILE: sv/rlwq_out_if.sv
interface rlwq_out_if;
  logic                             valid;
  logic                             ready;
  logic                             granted;
  logic                             blocked;
  logic                             wake_valid;
  logic [rlwq_pkg::THREAD_BITS-1:0] wake_thread;
  logic [1:0]                       error;

  modport source (output valid, output granted, output blocked, output wake_valid,
                  output wake_thread, output error, input ready);
  modport sink   (input valid, input granted, input blocked, input wake_valid,
                  input wake_thread, input error, output ready);
endinterface

FILE: sv/recursive_lock_with_wait_queue.sv
// Flow: a request transfer captures the request and reads the head entry of the wait
// queue; the decide step then puts the result in the output register. No new request
// is taken until that decide step is done, due to the read-then-update pass over the
// wait queue memory; the decide step waits while the output register is still full.
// Reset: synchronous, active low; the lock is free, the queue is empty and no result
// is pending. The queue memory is not cleared; entries are read only after written.
module recursive_lock_with_wait_queue (
  input  logic              clk,
  input  logic              rst_n,
  rlwq_in_if.sink           in_ch,
  rlwq_out_if.source        out_ch
);

  // Lock state lives in a few flops; waiter ids live in a single-port-read memory.
  rlwq_pkg::state_t                     state_r, state_nxt;
  logic                                 lock_taken_r, lock_taken_nxt;
  logic [rlwq_pkg::THREAD_BITS-1:0]     owner_r, owner_nxt;
  logic [rlwq_pkg::NEST_BITS-1:0]       nest_r, nest_nxt;
  logic [rlwq_pkg::QPTR_BITS-1:0]       head_r, head_nxt;
  logic [rlwq_pkg::QPTR_BITS-1:0]       tail_r, tail_nxt;
  logic [rlwq_pkg::QUSED_BITS-1:0]      used_r, used_nxt;

  // The request captured at transfer time.
  logic                                 cmd_r;
  logic [rlwq_pkg::THREAD_BITS-1:0]     tid_r;

  logic [rlwq_pkg::THREAD_BITS-1:0]     queue_mem [rlwq_pkg::QUEUE_DEPTH];
  logic [rlwq_pkg::THREAD_BITS-1:0]     queue_rd_r;

  // Output register.
  logic                                 out_valid_r;
  logic                                 granted_r, granted_nxt;
  logic                                 blocked_r, blocked_nxt;
  logic                                 wake_valid_r, wake_valid_nxt;
  logic [rlwq_pkg::THREAD_BITS-1:0]     wake_thread_r, wake_thread_nxt;
  rlwq_pkg::err_t                       error_r, error_nxt;

  logic in_fire;
  logic exec_fire;
  logic push;

  // Next state: a transfer moves us to the decide step, which finishes once the
  // output register can take the result.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlwq_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = rlwq_pkg::ST_EXEC;
      end
      rlwq_pkg::ST_EXEC: begin
        if (!out_valid_r || out_ch.ready) state_nxt = rlwq_pkg::ST_IDLE;
      end
      default: state_nxt = rlwq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    exec_fire   = 1'b0;
    case (state_r)
      rlwq_pkg::ST_IDLE: in_ch.ready = 1'b1;
      rlwq_pkg::ST_EXEC: exec_fire   = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        exec_fire   = 1'b0;
      end
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  // Decision logic. The head entry was read when the request was taken in, and no
  // write can land between that read and this step, so queue_rd_r is current.
  always_comb begin
    lock_taken_nxt  = lock_taken_r;
    owner_nxt       = owner_r;
    nest_nxt        = nest_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    used_nxt        = used_r;
    push            = 1'b0;
    granted_nxt     = 1'b0;
    blocked_nxt     = 1'b0;
    wake_valid_nxt  = 1'b0;
    wake_thread_nxt = '0;
    error_nxt       = rlwq_pkg::ERR_NONE;

    if (cmd_r == rlwq_pkg::CMD_ACQUIRE) begin
      if (lock_taken_r && owner_r == tid_r) begin
        // Nested acquire by the holder, unless the count is already at its ceiling.
        if (nest_r == rlwq_pkg::NEST_MAX) begin
          error_nxt = rlwq_pkg::ERR_NEST_SAT;
        end else begin
          nest_nxt    = nest_r + rlwq_pkg::NEST_ONE;
          granted_nxt = 1'b1;
        end
      end else if (!lock_taken_r) begin
        lock_taken_nxt = 1'b1;
        owner_nxt      = tid_r;
        nest_nxt       = rlwq_pkg::NEST_ONE;
        granted_nxt    = 1'b1;
      end else if (used_r >= rlwq_pkg::QUSED_FULL) begin
        error_nxt = rlwq_pkg::ERR_QUEUE_FULL;
      end else begin
        push        = 1'b1;
        tail_nxt    = (tail_r == rlwq_pkg::QPTR_LAST) ? '0 : tail_r + 1'b1;
        used_nxt    = used_r + 1'b1;
        blocked_nxt = 1'b1;
      end
    end else begin
      if (!lock_taken_r || owner_r != tid_r) begin
        error_nxt = rlwq_pkg::ERR_NOT_HOLDER;
      end else if (nest_r > rlwq_pkg::NEST_ONE) begin
        nest_nxt = nest_r - rlwq_pkg::NEST_ONE;
      end else begin
        // Last release frees the lock and wakes the oldest waiter, if there is one.
        lock_taken_nxt = 1'b0;
        owner_nxt      = '0;
        nest_nxt       = '0;
        if (used_r != '0) begin
          head_nxt        = (head_r == rlwq_pkg::QPTR_LAST) ? '0 : head_r + 1'b1;
          used_nxt        = used_r - 1'b1;
          wake_valid_nxt  = 1'b1;
          wake_thread_nxt = queue_rd_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rlwq_pkg::ST_IDLE;
      lock_taken_r <= 1'b0;
      owner_r      <= '0;
      nest_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        lock_taken_r <= lock_taken_nxt;
        owner_r      <= owner_nxt;
        nest_r       <= nest_nxt;
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        used_r       <= used_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Request capture and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.command;
      tid_r <= in_ch.thread;
    end
    if (exec_fire) begin
      granted_r     <= granted_nxt;
      blocked_r     <= blocked_nxt;
      wake_valid_r  <= wake_valid_nxt;
      wake_thread_r <= wake_thread_nxt;
      error_r       <= error_nxt;
    end
  end

  // Wait queue memory: the head is read as a request comes in, the tail written
  // when the decision queues a waiter.
  always_ff @(posedge clk) begin
    if (in_fire) queue_rd_r <= queue_mem[head_r];
    if (exec_fire && push) queue_mem[tail_r] <= tid_r;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = granted_r;
  assign out_ch.blocked     = blocked_r;
  assign out_ch.wake_valid  = wake_valid_r;
  assign out_ch.wake_thread = wake_thread_r;
  assign out_ch.error       = error_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= rlwq_pkg::QUSED_FULL)
    else $error("waiter count exceeds queue depth");

  a_ptr_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0 || used_r == rlwq_pkg::QUSED_FULL) |-> head_r == tail_r)
    else $error("queue pointers disagree with waiter count");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rlwq_pkg::ST_EXEC))
    else $error("result appeared without a decide step");

  a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && granted_nxt) |=> (lock_taken_r && owner_r == $past(tid_r)))
    else $error("grant did not leave the requester holding the lock");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({granted_r, blocked_r, wake_valid_r}) <= 1)
    else $error("result reports more than one outcome");
`endif

endmodule

FILE: verif/recursive_lock_with_wait_queue_tb.sv
module recursive_lock_with_wait_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves ample margin for the spacing between requests and for random
  // stalls on both channels.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 7;
  localparam int unsigned CALM_FIRST    = 500;
  localparam int unsigned CALM_LAST     = 800;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned BURST_LEN     = 50;

  typedef logic [rlwq_pkg::THREAD_BITS-1:0] tid_t;
  typedef logic [rlwq_pkg::NEST_BITS-1:0]   nest_t;

  typedef struct {
    rlwq_pkg::cmd_t command;
    tid_t           thread;
  } lock_req_t;

  typedef struct {
    logic           granted;
    logic           blocked;
    logic           wake_valid;
    tid_t           wake_thread;
    rlwq_pkg::err_t error;
  } lock_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rlwq_in_if  req_if ();
  rlwq_out_if rsp_if ();

  recursive_lock_with_wait_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  // The 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own picture of the lock: whether it is held, by whom, how deep the holder
  // has nested, and the ids waiting in arrival order.
  logic  lock_held   = 1'b0;
  tid_t  lock_holder = '0;
  nest_t hold_depth  = '0;
  tid_t  waiters[$];

  // Requests not yet offered to the block, and results we still owe a check.
  lock_req_t pending_reqs[$];
  lock_rsp_t rsp_due[$];

  // Set at a rising edge where the request transfer completed; the driver uses it
  // at the following falling edge to move on to the next request.
  logic req_taken = 1'b0;

  int unsigned n_req = 0;
  int unsigned n_rsp = 0;
  int unsigned n_grant = 0;
  int unsigned n_queued = 0;
  int unsigned n_wake = 0;
  int unsigned n_not_holder = 0;
  int unsigned n_full = 0;
  int unsigned n_sat = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Applies one request to the lock picture and returns the answer the block must give.
  function automatic lock_rsp_t arbitrate_request(lock_req_t r);
    lock_rsp_t rsp;
    rsp = '{granted: 1'b0, blocked: 1'b0, wake_valid: 1'b0, wake_thread: '0,
            error: rlwq_pkg::ERR_NONE};
    if (r.command == rlwq_pkg::CMD_ACQUIRE) begin
      if (lock_held && lock_holder == r.thread) begin
        // The holder nests again, unless the count has hit its ceiling.
        if (hold_depth == rlwq_pkg::NEST_MAX) begin
          rsp.error = rlwq_pkg::ERR_NEST_SAT;
        end else begin
          hold_depth++;
          rsp.granted = 1'b1;
        end
      end else if (!lock_held) begin
        // A free lock goes to any requester; the stale owner id plays no part.
        lock_held   = 1'b1;
        lock_holder = r.thread;
        hold_depth  = nest_t'(1);
        rsp.granted = 1'b1;
      end else if (waiters.size() >= rlwq_pkg::QUEUE_DEPTH) begin
        rsp.error = rlwq_pkg::ERR_QUEUE_FULL;
      end else begin
        // No duplicate check: a thread already waiting is queued a second time.
        waiters.push_back(r.thread);
        rsp.blocked = 1'b1;
      end
    end else begin
      if (!lock_held || lock_holder != r.thread) begin
        rsp.error = rlwq_pkg::ERR_NOT_HOLDER;
      end else if (hold_depth > 1) begin
        hold_depth--;
      end else begin
        // The last release frees the lock and wakes the oldest waiter, if any.
        // The woken thread is not granted anything; it has to acquire again.
        lock_held   = 1'b0;
        lock_holder = '0;
        hold_depth  = '0;
        if (waiters.size() > 0) begin
          rsp.wake_valid  = 1'b1;
          rsp.wake_thread = waiters.pop_front();
        end
      end
    end
    n_grant  += rsp.granted;
    n_queued += rsp.blocked;
    n_wake   += rsp.wake_valid;
    n_not_holder += (rsp.error == rlwq_pkg::ERR_NOT_HOLDER);
    n_full   += (rsp.error == rlwq_pkg::ERR_QUEUE_FULL);
    n_sat    += (rsp.error == rlwq_pkg::ERR_NEST_SAT);
    return rsp;
  endfunction

  function automatic bit in_calm_stretch(int unsigned count);
    return count >= CALM_FIRST && count < CALM_LAST;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_req(rlwq_pkg::cmd_t command, tid_t thread);
    pending_reqs.push_back('{command: command, thread: thread});
  endtask

  // Driver. A request stays on the channel until it is taken; a new one is offered
  // only after that, and then not in the random idle cycles. Idling is switched off
  // for a stretch of requests in the middle of the random part.
  always @(negedge clk) begin
    lock_req_t nxt;
    if (!req_if.valid || req_taken) begin
      if (pending_reqs.size() == 0 ||
          (!in_calm_stretch(n_req) && $urandom_range(0, 99) < IDLE_PCT)) begin
        req_if.valid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        req_if.valid   <= 1'b1;
        req_if.command <= nxt.command;
        req_if.thread  <= nxt.thread;
      end
    end
  end

  // The result side stalls at random too, with its own calm stretch.
  always @(negedge clk) begin
    rsp_if.ready <= in_calm_stretch(n_rsp) || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor. The result transfer is checked before the request transfer of the same
  // edge is predicted, so that a spurious result can never match a fresh prediction.
  always @(posedge clk) begin
    lock_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      if (rsp_due.size() == 0) begin
        $error({"result with no request outstanding: ",
                "granted %0d blocked %0d wake %0d/%0d error %0d"},
               rsp_if.granted, rsp_if.blocked, rsp_if.wake_valid, rsp_if.wake_thread,
               rsp_if.error);
        fail_count++;
      end else begin
        want = rsp_due.pop_front();
        check_field("granted", 8'(want.granted), 8'(rsp_if.granted));
        check_field("blocked", 8'(want.blocked), 8'(rsp_if.blocked));
        check_field("wake_valid", 8'(want.wake_valid), 8'(rsp_if.wake_valid));
        check_field("wake_thread", 8'(want.wake_thread), 8'(rsp_if.wake_thread));
        check_field("error", 8'(want.error), 8'(rsp_if.error));
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      n_req++;
      rsp_due.push_back(arbitrate_request('{command: rlwq_pkg::cmd_t'(req_if.command),
                                            thread: req_if.thread}));
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("recursive_lock_with_wait_queue verification failed");
      $finish;
    end
  end

  // Holds the sender back until every request has gone out and every result is in.
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || rsp_due.size() != 0);
    @(posedge clk);
  endtask

  // The directed opening walks the lock through each corner once: a release of a free
  // lock, thread zero taking and nesting the lock, a release by thread zero while
  // thread FF holds the lock, sixteen waiters with repeats until the queue is full,
  // one more that is refused, and the last release that wakes the oldest waiter.
  task automatic queue_directed();
    push_req(rlwq_pkg::CMD_RELEASE, tid_t'(8'h05));
    push_req(rlwq_pkg::CMD_ACQUIRE, tid_t'(8'h00));
    push_req(rlwq_pkg::CMD_ACQUIRE, tid_t'(8'h00));
    push_req(rlwq_pkg::CMD_RELEASE, tid_t'(8'h00));
    push_req(rlwq_pkg::CMD_RELEASE, tid_t'(8'h00));
    push_req(rlwq_pkg::CMD_ACQUIRE, tid_t'(8'hFF));
    push_req(rlwq_pkg::CMD_RELEASE, tid_t'(8'h00));
    for (int i = 0; i < rlwq_pkg::QUEUE_DEPTH; i++) begin
      push_req(rlwq_pkg::CMD_ACQUIRE, tid_t'((i % 8) * 8'h11 + 1));
    end
    push_req(rlwq_pkg::CMD_ACQUIRE, tid_t'(8'hAA));
    push_req(rlwq_pkg::CMD_RELEASE, tid_t'(8'hFF));
  endtask

  // Random traffic comes in bursts. Each burst picks a small set of thread ids and a
  // leaning toward acquires or releases, so that the holder often releases its own
  // lock, nesting gets deep, and the queue both fills and drains. A few requests in
  // each burst come from any thread at all.
  task automatic queue_random(int unsigned count);
    tid_t        pool[5];
    int unsigned pool_size;
    int unsigned acq_pct;
    int unsigned left;
    left = count;
    while (left > 0) begin
      pool_size = $urandom_range(1, 5);
      acq_pct   = $urandom_range(25, 75);
      foreach (pool[k]) begin
        pool[k] = tid_t'($urandom_range(0, (1 << rlwq_pkg::THREAD_BITS) - 1));
      end
      for (int b = 0; b < BURST_LEN && left > 0; b++) begin
        if ($urandom_range(0, 99) < 5) begin
          push_req(rlwq_pkg::cmd_t'($urandom_range(0, 1)),
                   tid_t'($urandom_range(0, (1 << rlwq_pkg::THREAD_BITS) - 1)));
        end else begin
          push_req(($urandom_range(0, 99) < acq_pct) ? rlwq_pkg::CMD_ACQUIRE
                                                     : rlwq_pkg::CMD_RELEASE,
                   pool[$urandom_range(0, pool_size - 1)]);
        end
        left--;
      end
    end
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.command = rlwq_pkg::CMD_ACQUIRE;
    req_if.thread  = '0;
    rsp_if.ready   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    queue_directed();
    wait_for_quiet();
    queue_random(RANDOM_ITEMS / 2);
    // The sender holds off here until the block has answered everything.
    wait_for_quiet();
    queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_for_quiet();

    // Anything the block sends now has no request behind it and is flagged.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d grants, %0d waiters queued, %0d wake-ups.",
             n_req, n_grant, n_queued, n_wake);
    $display("Refusals: %0d by a non-holder, %0d on a full queue, %0d at the ceiling.",
             n_not_holder, n_full, n_sat);
    if (fail_count == 0) begin
      $display("recursive_lock_with_wait_queue verification clean");
    end else begin
      $display("recursive_lock_with_wait_queue verification failed");
    end
    $finish;
  end

endmodule

FILE: recursive_lock_with_wait_queue.f
sv/rlwq_pkg.sv
sv/rlwq_in_if.sv
sv/rlwq_out_if.sv
sv/recursive_lock_with_wait_queue.sv
verif/recursive_lock_with_wait_queue_tb.sv
